// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms, sampled on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sip_pkg.sv -----
// ----------------------------------------------------------------------------
// sip_pkg
// Types and constants shared by the segment intersection blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sip_pkg;

  // width of the fixed-point crossing coordinates on the result item
  localparam int OUT_W = 20;

  typedef logic [OUT_W-1:0] fix_t;

endpackage

// ----- rtl/sip_front.sv -----
// ----------------------------------------------------------------------------
// sip_front
// Six-stage geometry front end: line products, crossing numerators and
// denominator, sign normalization and inclusive span tests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sip_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  in_valid_i,
  input  logic [COORD_BITS-1:0] x1_i,
  input  logic [COORD_BITS-1:0] y1_i,
  input  logic [COORD_BITS-1:0] x2_i,
  input  logic [COORD_BITS-1:0] y2_i,
  input  logic [COORD_BITS-1:0] x3_i,
  input  logic [COORD_BITS-1:0] y3_i,
  input  logic [COORD_BITS-1:0] x4_i,
  input  logic [COORD_BITS-1:0] y4_i,
  output logic                  out_valid_o,
  output logic                  hit_o,
  output logic [3*COORD_BITS:0] nx_o,
  output logic [3*COORD_BITS:0] ny_o,
  output logic [2*COORD_BITS:0] d_o
);

  localparam int C    = COORD_BITS;
  localparam int SW   = C + 1;       // coordinate differences
  localparam int UP   = 2 * C;       // unsigned coordinate products
  localparam int PW   = 2 * C + 2;   // signed first-level products
  localparam int CW   = 2 * C + 1;   // line constants
  localparam int MW   = 3 * C + 2;   // signed numerators
  localparam int DW   = 2 * C + 1;   // denominator magnitude
  localparam int UW   = 3 * C + 1;   // span bound times denominator
  localparam int NSTG = 6;

  localparam int SP_LXA = 0;
  localparam int SP_HXA = 1;
  localparam int SP_LXB = 2;
  localparam int SP_HXB = 3;
  localparam int SP_LYV = 4;
  localparam int SP_HYV = 5;
  localparam int SP_N   = 6;

  logic [NSTG-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // ---------------- stage 1: differences and first products ----------------
  logic signed [SW-1:0] sx1, sy1, sx2, sy2, sx3, sy3, sx4, sy4;
  logic signed [SW-1:0] dxa, dya, dxb, dyb, dx13, dx31;
  logic                 va, vb;
  logic [SP_N-1:0][C-1:0] sp1;

  assign sx1  = $signed({1'b0, x1_i});
  assign sy1  = $signed({1'b0, y1_i});
  assign sx2  = $signed({1'b0, x2_i});
  assign sy2  = $signed({1'b0, y2_i});
  assign sx3  = $signed({1'b0, x3_i});
  assign sy3  = $signed({1'b0, y3_i});
  assign sx4  = $signed({1'b0, x4_i});
  assign sy4  = $signed({1'b0, y4_i});
  assign dxa  = sx2 - sx1;
  assign dya  = sy2 - sy1;
  assign dxb  = sx4 - sx3;
  assign dyb  = sy4 - sy3;
  assign dx13 = sx1 - sx3;
  assign dx31 = sx3 - sx1;
  assign va   = (x1_i == x2_i);
  assign vb   = (x3_i == x4_i);

  // y span comes from whichever segment is vertical
  always_comb begin
    sp1[SP_LXA] = (x1_i < x2_i) ? x1_i : x2_i;
    sp1[SP_HXA] = (x1_i < x2_i) ? x2_i : x1_i;
    sp1[SP_LXB] = (x3_i < x4_i) ? x3_i : x4_i;
    sp1[SP_HXB] = (x3_i < x4_i) ? x4_i : x3_i;
    if (va) begin
      sp1[SP_LYV] = (y1_i < y2_i) ? y1_i : y2_i;
      sp1[SP_HYV] = (y1_i < y2_i) ? y2_i : y1_i;
    end else begin
      sp1[SP_LYV] = (y3_i < y4_i) ? y3_i : y4_i;
      sp1[SP_HYV] = (y3_i < y4_i) ? y4_i : y3_i;
    end
  end

  logic [UP-1:0]        p_x1y2_q, p_y1x2_q, p_x3y4_q, p_y3x4_q;
  logic signed [PW-1:0] p_dd1_q, p_dd2_q;
  logic signed [PW-1:0] p_vax_q, p_vay1_q, p_vay2_q;
  logic signed [PW-1:0] p_vbx_q, p_vby1_q, p_vby2_q;
  logic signed [SW-1:0] dxa1_q, dya1_q, dxb1_q, dyb1_q;
  logic                 va1_q, vb1_q;
  logic [SP_N-1:0][C-1:0] sp1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_x1y2_q <= UP'(x1_i) * UP'(y2_i);
      p_y1x2_q <= UP'(y1_i) * UP'(x2_i);
      p_x3y4_q <= UP'(x3_i) * UP'(y4_i);
      p_y3x4_q <= UP'(y3_i) * UP'(x4_i);
      p_dd1_q  <= PW'(dxa) * PW'(dyb);
      p_dd2_q  <= PW'(dya) * PW'(dxb);
      p_vax_q  <= PW'(sx1) * PW'(dxb);
      p_vay1_q <= PW'(sy3) * PW'(dxb);
      p_vay2_q <= PW'(dyb) * PW'(dx13);
      p_vbx_q  <= PW'(sx3) * PW'(dxa);
      p_vby1_q <= PW'(sy1) * PW'(dxa);
      p_vby2_q <= PW'(dya) * PW'(dx31);
      dxa1_q   <= dxa;
      dya1_q   <= dya;
      dxb1_q   <= dxb;
      dyb1_q   <= dyb;
      va1_q    <= va;
      vb1_q    <= vb;
      sp1_q    <= sp1;
    end
  end

  // ---------------- stage 2: line constants, vertical-case terms ----------------
  logic signed [CW-1:0] ca2_q, cb2_q;
  logic signed [PW-1:0] dgen2_q, dv2_q, nxv2_q, nyv2_q;
  logic signed [SW-1:0] dxa2_q, dya2_q, dxb2_q, dyb2_q;
  logic                 va2_q, vb2_q;
  logic [SP_N-1:0][C-1:0] sp2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca2_q   <= $signed({1'b0, p_x1y2_q}) - $signed({1'b0, p_y1x2_q});
      cb2_q   <= $signed({1'b0, p_x3y4_q}) - $signed({1'b0, p_y3x4_q});
      dgen2_q <= p_dd1_q - p_dd2_q;
      if (va1_q) begin
        dv2_q  <= PW'(dxb1_q);
        nxv2_q <= p_vax_q;
        nyv2_q <= p_vay1_q + p_vay2_q;
      end else begin
        dv2_q  <= PW'(dxa1_q);
        nxv2_q <= p_vbx_q;
        nyv2_q <= p_vby1_q + p_vby2_q;
      end
      dxa2_q <= dxa1_q;
      dya2_q <= dya1_q;
      dxb2_q <= dxb1_q;
      dyb2_q <= dyb1_q;
      va2_q  <= va1_q;
      vb2_q  <= vb1_q;
      sp2_q  <= sp1_q;
    end
  end

  // ---------------- stage 3: general-case numerator products ----------------
  logic signed [MW-1:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [PW-1:0] dgen3_q, dv3_q, nxv3_q, nyv3_q;
  logic                 va3_q, vb3_q;
  logic [SP_N-1:0][C-1:0] sp3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q    <= MW'(dxa2_q) * MW'(cb2_q);
      m2_q    <= MW'(ca2_q) * MW'(dxb2_q);
      m3_q    <= MW'(dya2_q) * MW'(cb2_q);
      m4_q    <= MW'(ca2_q) * MW'(dyb2_q);
      dgen3_q <= dgen2_q;
      dv3_q   <= dv2_q;
      nxv3_q  <= nxv2_q;
      nyv3_q  <= nyv2_q;
      va3_q   <= va2_q;
      vb3_q   <= vb2_q;
      sp3_q   <= sp2_q;
    end
  end

  // ---------------- stage 4: case select, make denominator positive ----------------
  logic                 general;
  logic signed [MW-1:0] nsel_x, nsel_y;
  logic signed [PW-1:0] dsel, dabs;
  logic                 dneg;

  assign general = !va3_q && !vb3_q;
  assign nsel_x  = general ? (m1_q - m2_q) : MW'(nxv3_q);
  assign nsel_y  = general ? (m3_q - m4_q) : MW'(nyv3_q);
  assign dsel    = general ? dgen3_q : dv3_q;
  assign dneg    = dsel[PW-1];
  assign dabs    = dneg ? -dsel : dsel;

  logic signed [MW-1:0] nx4_q, ny4_q;
  logic [DW-1:0]        d4_q;
  logic                 nohit4_q, vert4_q;
  logic [SP_N-1:0][C-1:0] sp4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx4_q    <= dneg ? -nsel_x : nsel_x;
      ny4_q    <= dneg ? -nsel_y : nsel_y;
      d4_q     <= dabs[DW-1:0];
      // both vertical, or parallel lines
      nohit4_q <= (va3_q && vb3_q) || (general && (dgen3_q == '0));
      vert4_q  <= va3_q || vb3_q;
      sp4_q    <= sp3_q;
    end
  end

  // ---------------- stage 5: span bounds scaled by the denominator ----------------
  logic [SP_N-1:0][UW-1:0] pr5_q;
  logic signed [MW-1:0]    nx5_q, ny5_q;
  logic [DW-1:0]           d5_q;
  logic                    nohit5_q, vert5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SP_N; k++) begin
        pr5_q[k] <= UW'(sp4_q[k]) * UW'(d4_q);
      end
      nx5_q    <= nx4_q;
      ny5_q    <= ny4_q;
      d5_q     <= d4_q;
      nohit5_q <= nohit4_q;
      vert5_q  <= vert4_q;
    end
  end

  // ---------------- stage 6: inclusive span tests ----------------
  logic in_xa, in_xb, in_yv, hit6;

  assign in_xa = ($signed({1'b0, pr5_q[SP_LXA]}) <= nx5_q) &&
                 (nx5_q <= $signed({1'b0, pr5_q[SP_HXA]}));
  assign in_xb = ($signed({1'b0, pr5_q[SP_LXB]}) <= nx5_q) &&
                 (nx5_q <= $signed({1'b0, pr5_q[SP_HXB]}));
  assign in_yv = ($signed({1'b0, pr5_q[SP_LYV]}) <= ny5_q) &&
                 (ny5_q <= $signed({1'b0, pr5_q[SP_HYV]}));
  assign hit6  = !nohit5_q && in_xa && in_xb && (!vert5_q || in_yv);

  logic          hit6_q;
  logic [UW-1:0] nx6_q, ny6_q;
  logic [DW-1:0] d6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit6_q <= hit6;
      nx6_q  <= nx5_q[MW-1] ? '0 : nx5_q[UW-1:0];
      ny6_q  <= ny5_q[MW-1] ? '0 : ny5_q[UW-1:0];
      d6_q   <= d5_q;
    end
  end

  assign out_valid_o = v_q[NSTG-1];
  assign hit_o       = hit6_q;
  assign nx_o        = nx6_q;
  assign ny_o        = ny6_q;
  assign d_o         = d6_q;

endmodule

// ----- rtl/sip_div.sv -----
// ----------------------------------------------------------------------------
// sip_div
// Pipelined restoring divider for both crossing coordinates: one quotient
// bit per stage, shared denominator, result truncated to fixed point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sip_div #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  in_valid_i,
  input  logic                  hit_i,
  input  logic [3*COORD_BITS:0] nx_i,
  input  logic [3*COORD_BITS:0] ny_i,
  input  logic [2*COORD_BITS:0] d_i,
  output logic                  out_valid_o,
  output logic                  hit_o,
  output sip_pkg::fix_t         cross_x_o,
  output sip_pkg::fix_t         cross_y_o
);

  import sip_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DW  = 2 * C + 1;   // divisor and partial remainder
  localparam int NNW = 3 * C + 1;   // numerator
  localparam int NW  = NNW + F;     // numerator scaled by 2^F
  localparam int QW  = C + F;       // quotient bits (crossing < 2^C)

  logic [QW:0]   v_q;
  logic [QW:0]   hit_q;
  logic [DW-1:0] d_q  [QW+1];
  logic [DW-1:0] rx_q [QW+1];
  logic [DW-1:0] ry_q [QW+1];
  logic [QW-1:0] lx_q [QW+1];
  logic [QW-1:0] ly_q [QW+1];
  logic [QW-1:0] qx_q [QW+1];
  logic [QW-1:0] qy_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= {hit_q[QW-1:0], hit_i};
    end
  end

  // stage 0: top DW bits of the scaled numerator form the first remainder,
  // which is below the divisor whenever the crossing is in range
  logic [NW-1:0] nwx, nwy;

  assign nwx = NW'(nx_i) << F;
  assign nwy = NW'(ny_i) << F;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0]  <= d_i;
      rx_q[0] <= nwx[NW-1:QW];
      ry_q[0] <= nwy[NW-1:QW];
      lx_q[0] <= nwx[QW-1:0];
      ly_q[0] <= nwy[QW-1:0];
      qx_q[0] <= '0;
      qy_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] tx, ty, dd, sx, sy;
    logic        gx, gy;

    assign dd = {1'b0, d_q[k]};
    assign tx = {rx_q[k], lx_q[k][QW-1]};
    assign ty = {ry_q[k], ly_q[k][QW-1]};
    assign gx = (tx >= dd);
    assign gy = (ty >= dd);
    assign sx = tx - dd;
    assign sy = ty - dd;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k+1]  <= d_q[k];
        rx_q[k+1] <= gx ? sx[DW-1:0] : tx[DW-1:0];
        ry_q[k+1] <= gy ? sy[DW-1:0] : ty[DW-1:0];
        lx_q[k+1] <= lx_q[k] << 1;
        ly_q[k+1] <= ly_q[k] << 1;
        qx_q[k+1] <= {qx_q[k][QW-2:0], gx};
        qy_q[k+1] <= {qy_q[k][QW-2:0], gy};
      end
    end
  end

  // quotient zero-extended or truncated to the result width
  logic [QW+OUT_W-1:0] qx_ext, qy_ext;

  assign qx_ext = {{OUT_W{1'b0}}, qx_q[QW]};
  assign qy_ext = {{OUT_W{1'b0}}, qy_q[QW]};

  assign out_valid_o = v_q[QW];
  assign hit_o       = hit_q[QW];
  assign cross_x_o   = hit_q[QW] ? qx_ext[OUT_W-1:0] : '0;
  assign cross_y_o   = hit_q[QW] ? qy_ext[OUT_W-1:0] : '0;

endmodule

// ----- rtl/segment_intersection_point.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_point
// Tests two integer line segments for a crossing and reports the crossing
// point in unsigned fixed point with FRAC_BITS fraction bits, truncated;
// hit_o is low and both coordinates are zero when the segments do not cross
// (both vertical and equal slopes, collinear included, never hit). The block
// is fully pipelined and takes one item per cycle while in_stall_o is low.
// An item passes six stages of products, numerators and span tests, then a
// divider that settles one quotient bit per stage for x and y together. A
// one-item output register absorbs a stalled result; while it is occupied
// the pipeline holds and in_stall_o is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_intersection_point #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] a_start_x_i,
  input  logic [COORD_BITS-1:0] a_start_y_i,
  input  logic [COORD_BITS-1:0] a_end_x_i,
  input  logic [COORD_BITS-1:0] a_end_y_i,
  input  logic [COORD_BITS-1:0] b_start_x_i,
  input  logic [COORD_BITS-1:0] b_start_y_i,
  input  logic [COORD_BITS-1:0] b_end_x_i,
  input  logic [COORD_BITS-1:0] b_end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output sip_pkg::fix_t         cross_x_o,
  output sip_pkg::fix_t         cross_y_o
);

  import sip_pkg::*;

  logic                  en;
  logic                  fr_valid, fr_hit;
  logic [3*COORD_BITS:0] fr_nx, fr_ny;
  logic [2*COORD_BITS:0] fr_d;
  logic                  dv_valid, dv_hit;
  fix_t                  dv_x, dv_y;

  logic skid_full_q;
  logic skid_hit_q;
  fix_t skid_x_q, skid_y_q;

  // the whole pipeline advances unless the output register holds an item
  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  sip_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .x1_i       (a_start_x_i),
    .y1_i       (a_start_y_i),
    .x2_i       (a_end_x_i),
    .y2_i       (a_end_y_i),
    .x3_i       (b_start_x_i),
    .y3_i       (b_start_y_i),
    .x4_i       (b_end_x_i),
    .y4_i       (b_end_y_i),
    .out_valid_o(fr_valid),
    .hit_o      (fr_hit),
    .nx_o       (fr_nx),
    .ny_o       (fr_ny),
    .d_o        (fr_d)
  );

  sip_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (fr_valid),
    .hit_i      (fr_hit),
    .nx_i       (fr_nx),
    .ny_i       (fr_ny),
    .d_i        (fr_d),
    .out_valid_o(dv_valid),
    .hit_o      (dv_hit),
    .cross_x_o  (dv_x),
    .cross_y_o  (dv_y)
  );

  // a result stalled at the pipeline end is parked here, holding the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      skid_full_q <= out_stall_i;
    end else begin
      skid_full_q <= dv_valid && out_stall_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      skid_hit_q <= dv_hit;
      skid_x_q   <= dv_x;
      skid_y_q   <= dv_y;
    end
  end

  assign out_valid_o = skid_full_q || dv_valid;
  assign hit_o       = skid_full_q ? skid_hit_q : dv_hit;
  assign cross_x_o   = skid_full_q ? skid_x_q : dv_x;
  assign cross_y_o   = skid_full_q ? skid_y_q : dv_y;

endmodule

// ----- rtl/sip_checker.sv -----
// ----------------------------------------------------------------------------
// sip_checker
// Port-level checks on the segment intersection block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sip_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input logic          hit_o,
  input sip_pkg::fix_t cross_x_o,
  input sip_pkg::fix_t cross_y_o
);

  `SIP_ASSERT_NEXT(a_out_valid_held, out_valid_o && out_stall_i, out_valid_o, "stalled result dropped")

  `SIP_ASSERT_NEXT(a_out_item_held, out_valid_o && out_stall_i, $stable(hit_o) && $stable(cross_x_o) && $stable(cross_y_o), "stalled result changed")

  `SIP_ASSERT_NOW(a_nohit_zero, out_valid_o && !hit_o, (cross_x_o == '0) && (cross_y_o == '0), "result without a hit carries a point")

  // input only stalls while a parked result is on the output
  `SIP_ASSERT_NOW(a_stall_needs_result, in_stall_o, out_valid_o, "input stalled with no result waiting")

endmodule

bind segment_intersection_point sip_checker u_sip_checker (.*);

// ----- verif/segment_intersection_point_test.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_point_test
// Self-checking bench for the segment crossing block. Segment pairs are fed
// through the valid/stall input channel: a directed set first, then shaped
// random pairs. Each accepted pair is scored against an exact integer
// predictor. Both channels idle at random in two mixes, then run flat out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

localparam int COORD_W = 12;
localparam int FRAC_W  = 8;

typedef logic [COORD_W-1:0] coord_t;

typedef struct packed {
  coord_t ax0, ay0, ax1, ay1;
  coord_t bx0, by0, bx1, by1;
} seg_pair_t;

typedef struct packed {
  logic          hit;
  sip_pkg::fix_t cx;
  sip_pkg::fix_t cy;
} crossing_t;

class crossing_board;
  crossing_t   pending_crossings[$];
  int unsigned errors = 0;

  // lo*d <= n <= hi*d, d > 0
  function bit in_span(longint n, longint d, longint e0, longint e1);
    longint lo, hi;
    lo = (e0 < e1) ? e0 : e1;
    hi = (e0 < e1) ? e1 : e0;
    return (lo * d <= n) && (n <= hi * d);
  endfunction

  // floor(n/d * 2^FRAC_W), negative numerators clamp to zero
  function sip_pkg::fix_t to_fixed(longint n, longint d);
    longint q, rem;
    if (n < 0) n = 0;
    q   = n / d;
    rem = n % d;
    return sip_pkg::fix_t'((q << FRAC_W) + ((rem << FRAC_W) / d));
  endfunction

  function crossing_t predict_crossing(seg_pair_t p);
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    longint dxa, dya, dxb, dyb, nx, ny, d, ca, cb;
    bit va, vb, hit;
    crossing_t r;
    r.hit = 1'b0;
    r.cx  = '0;
    r.cy  = '0;
    x1 = longint'(p.ax0);
    y1 = longint'(p.ay0);
    x2 = longint'(p.ax1);
    y2 = longint'(p.ay1);
    x3 = longint'(p.bx0);
    y3 = longint'(p.by0);
    x4 = longint'(p.bx1);
    y4 = longint'(p.by1);
    dxa = x2 - x1;
    dya = y2 - y1;
    dxb = x4 - x3;
    dyb = y4 - y3;
    va = (dxa == 0);
    vb = (dxb == 0);
    if (va && vb) return r;
    if (va) begin
      d  = dxb;
      nx = x1 * d;
      ny = y3 * d + dyb * (x1 - x3);
    end else if (vb) begin
      d  = dxa;
      nx = x3 * d;
      ny = y1 * d + dya * (x3 - x1);
    end else begin
      ca = x1 * y2 - y1 * x2;
      cb = x3 * y4 - y3 * x4;
      d  = dxa * dyb - dya * dxb;
      if (d == 0) return r;
      nx = dxa * cb - ca * dxb;
      ny = dya * cb - ca * dyb;
    end
    if (d < 0) begin
      d  = -d;
      nx = -nx;
      ny = -ny;
    end
    hit = in_span(nx, d, x1, x2) && in_span(nx, d, x3, x4);
    // a vertical segment also bounds the crossing in y
    if (hit && va) hit = in_span(ny, d, y1, y2);
    if (hit && vb) hit = in_span(ny, d, y3, y4);
    if (hit) begin
      r.hit = 1'b1;
      r.cx  = to_fixed(nx, d);
      r.cy  = to_fixed(ny, d);
    end
    return r;
  endfunction

  function void note_item(seg_pair_t p);
    pending_crossings.push_back(predict_crossing(p));
  endfunction

  function void check_result(logic hit, sip_pkg::fix_t cx, sip_pkg::fix_t cy);
    crossing_t want;
    if (pending_crossings.size() == 0) begin
      $display("%0t: unexpected item hit=%0b x=%05h y=%05h", $time, hit, cx, cy);
      errors++;
      return;
    end
    want = pending_crossings.pop_front();
    if (hit !== want.hit) begin
      $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
      errors++;
    end
    if (cx !== want.cx) begin
      $display("%0t: cross_x expected %05h actual %05h", $time, want.cx, cx);
      errors++;
    end
    if (cy !== want.cy) begin
      $display("%0t: cross_y expected %05h actual %05h", $time, want.cy, cy);
      errors++;
    end
  endfunction

  function int pending_count();
    return pending_crossings.size();
  endfunction
endclass

module segment_intersection_point_test;

  localparam int LATENCY          = COORD_W + FRAC_W + 7;
  localparam int RANDOM_PER_PHASE = 542;
  localparam int WATCHDOG_LIMIT   = 5000;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  coord_t        a_start_x_i = '0;
  coord_t        a_start_y_i = '0;
  coord_t        a_end_x_i   = '0;
  coord_t        a_end_y_i   = '0;
  coord_t        b_start_x_i = '0;
  coord_t        b_start_y_i = '0;
  coord_t        b_end_x_i   = '0;
  coord_t        b_end_y_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic          hit_o;
  sip_pkg::fix_t cross_x_o;
  sip_pkg::fix_t cross_y_o;

  int            tx_idle_pct  = 0;
  int            rx_idle_pct  = 0;
  int            quiet_cycles = 0;
  crossing_board board        = new;

  segment_intersection_point #(
    .COORD_BITS(COORD_W),
    .FRAC_BITS (FRAC_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .a_start_x_i(a_start_x_i),
    .a_start_y_i(a_start_y_i),
    .a_end_x_i  (a_end_x_i),
    .a_end_y_i  (a_end_y_i),
    .b_start_x_i(b_start_x_i),
    .b_start_y_i(b_start_y_i),
    .b_end_x_i  (b_end_x_i),
    .b_end_y_i  (b_end_y_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .hit_o      (hit_o),
    .cross_x_o  (cross_x_o),
    .cross_y_o  (cross_y_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(hit_o, cross_x_o, cross_y_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("segment_intersection_point test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_pair(input seg_pair_t p);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    a_start_x_i <= p.ax0;
    a_start_y_i <= p.ay0;
    a_end_x_i   <= p.ax1;
    a_end_y_i   <= p.ay1;
    b_start_x_i <= p.bx0;
    b_start_y_i <= p.by0;
    b_end_x_i   <= p.bx1;
    b_end_y_i   <= p.by1;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(p);
    @(negedge clk_i);
  endtask

  task automatic drive_coords(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
    seg_pair_t p;
    p = '{coord_t'(ax0), coord_t'(ay0), coord_t'(ax1), coord_t'(ay1),
          coord_t'(bx0), coord_t'(by0), coord_t'(bx1), coord_t'(by1)};
    drive_pair(p);
  endtask

  function automatic coord_t corner_coord();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return coord_t'(4095);
      2: return coord_t'(1);
      3: return coord_t'(4094);
      4: return coord_t'(2048);
      default: return coord_t'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t p, o;
    int kind, px, py, ux, uy, vx, vy, lo, hi, dx, dy;
    kind = $urandom_range(0, 99);
    p = {$urandom, $urandom, $urandom};
    o = {$urandom, $urandom, $urandom};
    if (kind < 20) begin
      // plain random pair, usually a miss
    end else if (kind < 35) begin
      // two segments through one lattice point
      px = $urandom_range(500, 3595);
      py = $urandom_range(500, 3595);
      ux = $urandom_range(0, 1000) - 500;
      uy = $urandom_range(0, 1000) - 500;
      vx = $urandom_range(0, 1000) - 500;
      vy = $urandom_range(0, 1000) - 500;
      p.ax0 = coord_t'(px - ux);
      p.ay0 = coord_t'(py - uy);
      p.ax1 = coord_t'(px + ($urandom_range(0, 1) ? ux : ux / 3));
      p.ay1 = coord_t'(py + ($urandom_range(0, 1) ? uy : uy / 3));
      p.bx0 = coord_t'(px - vx);
      p.by0 = coord_t'(py - vy);
      p.bx1 = coord_t'(px + vx);
      p.by1 = coord_t'(py + vy);
    end else if (kind < 50) begin
      // tight window: touching ends, shared slopes, degenerate shapes
      px = $urandom_range(0, 4095 - 15);
      py = $urandom_range(0, 4095 - 15);
      p.ax0 = coord_t'(px + $urandom_range(0, 15));
      p.ay0 = coord_t'(py + $urandom_range(0, 15));
      p.ax1 = coord_t'(px + $urandom_range(0, 15));
      p.ay1 = coord_t'(py + $urandom_range(0, 15));
      p.bx0 = coord_t'(px + $urandom_range(0, 15));
      p.by0 = coord_t'(py + $urandom_range(0, 15));
      p.bx1 = coord_t'(px + $urandom_range(0, 15));
      p.by1 = coord_t'(py + $urandom_range(0, 15));
    end else if (kind < 63) begin
      // one vertical segment placed within the other's x span
      lo = (o.ax0 < o.ax1) ? int'(o.ax0) : int'(o.ax1);
      hi = (o.ax0 < o.ax1) ? int'(o.ax1) : int'(o.ax0);
      vx = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? lo : hi)
                                      : $urandom_range(lo, hi);
      if ($urandom_range(0, 1)) begin
        p.ax1 = coord_t'(vx);
        p.ax0 = coord_t'(vx);
        p.bx0 = o.ax0;
        p.by0 = o.ay0;
        p.bx1 = o.ax1;
        p.by1 = o.ay1;
      end else begin
        p.bx1 = coord_t'(vx);
        p.bx0 = coord_t'(vx);
        p.ax0 = o.ax0;
        p.ay0 = o.ay0;
        p.ax1 = o.ax1;
        p.ay1 = o.ay1;
      end
    end else if (kind < 68) begin
      p.ax1 = p.ax0;
      p.bx1 = $urandom_range(0, 1) ? p.ax0 : p.bx0;
      p.bx0 = p.bx1;
    end else if (kind < 78) begin
      // equal slopes, often collinear
      dx = $urandom_range(0, 400) - 200;
      dy = $urandom_range(0, 400) - 200;
      px = $urandom_range(400, 3695);
      py = $urandom_range(400, 3695);
      p.ax0 = coord_t'(px);
      p.ay0 = coord_t'(py);
      p.ax1 = coord_t'(px + dx);
      p.ay1 = coord_t'(py + dy);
      if ($urandom_range(0, 1)) begin
        vx = px + dx;
        vy = py + dy;
      end else begin
        vx = $urandom_range(400, 3695);
        vy = $urandom_range(400, 3695);
      end
      p.bx0 = coord_t'(vx);
      p.by0 = coord_t'(vy);
      p.bx1 = coord_t'($urandom_range(0, 1) ? vx + dx : vx - dx);
      p.by1 = coord_t'((p.bx1 == coord_t'(vx + dx)) ? vy + dy : vy - dy);
    end else if (kind < 88) begin
      // a point against a segment
      case ($urandom_range(0, 2))
        0: begin px = int'(o.ax0); py = int'(o.ay0); end
        1: begin px = int'(o.ax1); py = int'(o.ay1); end
        default: begin
          px = (int'(o.ax0) + int'(o.ax1)) / 2;
          py = (int'(o.ay0) + int'(o.ay1)) / 2;
        end
      endcase
      if ($urandom_range(0, 1)) begin
        p = '{coord_t'(px), coord_t'(py), coord_t'(px), coord_t'(py),
              o.ax0, o.ay0, o.ax1, o.ay1};
      end else begin
        p = '{o.ax0, o.ay0, o.ax1, o.ay1,
              coord_t'(px), coord_t'(py), coord_t'(px), coord_t'(py)};
      end
    end else begin
      p = '{corner_coord(), corner_coord(), corner_coord(), corner_coord(),
            corner_coord(), corner_coord(), corner_coord(), corner_coord()};
    end
    return p;
  endfunction

  initial begin
    tx_idle_pct = 31;
    rx_idle_pct = 45;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    drive_coords(0, 0, 0, 0, 0, 0, 0, 0);
    drive_coords(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    drive_coords(0, 0, 4095, 4095, 0, 4095, 4095, 0);
    drive_coords(4095, 4095, 0, 0, 0, 4095, 4095, 0);
    drive_coords(100, 0, 100, 4095, 0, 200, 4095, 200);
    drive_coords(0, 200, 4095, 200, 100, 0, 100, 4095);
    drive_coords(100, 0, 100, 150, 0, 200, 4095, 200);
    drive_coords(4095, 0, 4095, 4095, 0, 0, 4095, 4095);
    drive_coords(10, 0, 10, 100, 20, 0, 30, 100);
    drive_coords(0, 0, 100, 100, 0, 10, 100, 110);
    drive_coords(0, 0, 100, 100, 50, 50, 150, 150);
    drive_coords(7, 0, 7, 100, 7, 50, 7, 200);
    drive_coords(50, 50, 50, 50, 0, 0, 100, 100);
    drive_coords(50, 51, 50, 51, 0, 0, 100, 100);
    drive_coords(9, 9, 9, 9, 9, 9, 9, 9);
    drive_coords(0, 0, 100, 100, 100, 100, 200, 0);
    drive_coords(0, 0, 10, 10, 100, 0, 90, 10);
    drive_coords(0, 0, 3, 1, 0, 1, 3, 0);
    drive_coords(0, 0, 3, 2, 0, 2, 3, 0);
    drive_coords(0, 4095, 4095, 0, 0, 0, 4095, 4094);
    drive_coords(0, 0, 4095, 4094, 0, 1, 4094, 4095);
    drive_coords('hAAA, 'h555, 'h555, 'hAAA, 'h555, 'h555, 'hAAA, 'hAAA);
    drive_coords(1, 0, 2, 3, 0, 1, 3, 2);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 45 : 0;
      rx_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 31 : 0;
      repeat (RANDOM_PER_PHASE) drive_pair(random_pair());
    end
    in_valid_i <= 1'b0;

    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("segment_intersection_point test passed");
    end else begin
      $display("segment_intersection_point test failed");
    end
    $finish;
  end

endmodule
